@@ rtl/clamped_block_averager_unit_defines.svh @@
// Assertion macros used by the averager control block (cba_ctrl).
`ifndef CLAMPED_BLOCK_AVERAGER_UNIT_DEFINES_SVH
`define CLAMPED_BLOCK_AVERAGER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define CBA_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cba assertion failed");

// Next-cycle implication, clocked on clock, off during reset.
`define CBA_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cba assertion failed");

`endif

@@ rtl/cba_pkg.sv @@
`default_nettype none

package cba_pkg;

   localparam int MAX_WINDOW     = 255;
   localparam int WINDOW_RESET   = 10;
   localparam int SUM_W          = 22;
   localparam int OUT_W          = 14;
   localparam int DIVD_W         = 23;
   localparam int DIVR_W         = 9;
   localparam int DIV_STEPS      = OUT_W;
   localparam int STEP_W         = $clog2(DIV_STEPS);

   localparam logic signed [15:0] TEMP_MIN = -16'sd4000;
   localparam logic signed [15:0] TEMP_MAX = 16'sd8000;
   localparam logic signed [15:0] HUMI_MIN = 16'sd0;
   localparam logic signed [15:0] HUMI_MAX = 16'sd10000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic accum;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic window_hit;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/cba_dp.sv @@
`default_nettype none

module cba_dp
   import cba_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [7:0]              csr_wr_data,
   input  wire logic                    req_sample_ok,
   input  wire logic signed [15:0]      req_temp_sample,
   input  wire logic signed [15:0]      req_humi_sample,
   input  wire cmd_type                 cmd,
   output status_type                   sts,
   output logic signed [OUT_W-1:0]      rsp_mean_temp,
   output logic [OUT_W-1:0]             rsp_mean_humi
);

   logic [7:0]              window_ff;
   logic [7:0]              window_in;
   logic [7:0]              win_eff;
   logic signed [SUM_W-1:0] temp_sum_ff, temp_sum_in;
   logic [SUM_W-1:0]        humi_sum_ff, humi_sum_in;
   logic [7:0]              count_ff, count_in;
   logic signed [OUT_W-1:0] temp_clamp;
   logic [OUT_W-1:0]        humi_clamp;
   logic [SUM_W-1:0]        temp_mag;
   logic [DIVD_W-1:0]       temp_divd, humi_divd;
   logic [DIVR_W-1:0]       divr_ff, divr_in;
   logic [DIVR_W-1:0]       t_rem_ff, t_rem_in, h_rem_ff, h_rem_in;
   logic [OUT_W-1:0]        t_quo_ff, t_quo_in, h_quo_ff, h_quo_in;
   logic                    t_neg_ff, t_neg_in;
   logic [DIVR_W:0]         t_shift, h_shift, t_diff, h_diff;
   logic signed [OUT_W-1:0] mean_temp_ff, mean_temp_in;
   logic [OUT_W-1:0]        mean_humi_ff, mean_humi_in;

   always_comb begin
      window_in = csr_wr_en ? csr_wr_data : window_ff;
      if (window_ff == 8'd0) begin
         win_eff = 8'd1;
      end else if (32'(window_ff) > MAX_WINDOW) begin
         win_eff = 8'(MAX_WINDOW);
      end else begin
         win_eff = window_ff;
      end
      sts.window_hit = (count_ff != 8'd0) && (count_ff >= win_eff);
   end

   always_comb begin
      if (req_temp_sample < TEMP_MIN) begin
         temp_clamp = OUT_W'(TEMP_MIN);
      end else if (req_temp_sample > TEMP_MAX) begin
         temp_clamp = OUT_W'(TEMP_MAX);
      end else begin
         temp_clamp = req_temp_sample[OUT_W-1:0];
      end
      if (req_humi_sample < HUMI_MIN) begin
         humi_clamp = OUT_W'(HUMI_MIN);
      end else if (req_humi_sample > HUMI_MAX) begin
         humi_clamp = OUT_W'(HUMI_MAX);
      end else begin
         humi_clamp = req_humi_sample[OUT_W-1:0];
      end
   end

   always_comb begin
      temp_mag  = temp_sum_ff[SUM_W-1] ? SUM_W'(-temp_sum_ff) : temp_sum_ff;
      temp_divd = {temp_mag, 1'b0} + DIVD_W'(count_ff);
      humi_divd = {humi_sum_ff, 1'b0} + DIVD_W'(count_ff);

      temp_sum_in = temp_sum_ff;
      humi_sum_in = humi_sum_ff;
      count_in    = count_ff;
      divr_in     = divr_ff;
      t_neg_in    = t_neg_ff;
      t_rem_in    = t_rem_ff;
      h_rem_in    = h_rem_ff;
      t_quo_in    = t_quo_ff;
      h_quo_in    = h_quo_ff;

      t_shift = {t_rem_ff, t_quo_ff[OUT_W-1]};
      h_shift = {h_rem_ff, h_quo_ff[OUT_W-1]};
      t_diff  = t_shift - {1'b0, divr_ff};
      h_diff  = h_shift - {1'b0, divr_ff};

      if (cmd.accum && req_sample_ok && (count_ff != 8'hFF)) begin
         temp_sum_in = temp_sum_ff + {{(SUM_W-OUT_W){temp_clamp[OUT_W-1]}}, temp_clamp};
         humi_sum_in = humi_sum_ff + {{(SUM_W-OUT_W){1'b0}}, humi_clamp};
         count_in    = count_ff + 8'd1;
      end

      if (cmd.div_load) begin
         divr_in     = {count_ff, 1'b0};
         t_neg_in    = temp_sum_ff[SUM_W-1];
         t_rem_in    = temp_divd[DIVD_W-1:OUT_W];
         t_quo_in    = temp_divd[OUT_W-1:0];
         h_rem_in    = humi_divd[DIVD_W-1:OUT_W];
         h_quo_in    = humi_divd[OUT_W-1:0];
         temp_sum_in = '0;
         humi_sum_in = '0;
         count_in    = 8'd0;
      end

      if (cmd.div_step) begin
         if (!t_diff[DIVR_W]) begin
            t_rem_in = t_diff[DIVR_W-1:0];
         end else begin
            t_rem_in = t_shift[DIVR_W-1:0];
         end
         t_quo_in = {t_quo_ff[OUT_W-2:0], ~t_diff[DIVR_W]};
         if (!h_diff[DIVR_W]) begin
            h_rem_in = h_diff[DIVR_W-1:0];
         end else begin
            h_rem_in = h_shift[DIVR_W-1:0];
         end
         h_quo_in = {h_quo_ff[OUT_W-2:0], ~h_diff[DIVR_W]};
      end

      mean_temp_in = mean_temp_ff;
      mean_humi_in = mean_humi_ff;
      if (cmd.out_load) begin
         mean_temp_in = t_neg_ff ? OUT_W'(-t_quo_ff) : t_quo_ff;
         mean_humi_in = h_quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= 8'(WINDOW_RESET);
         temp_sum_ff <= '0;
         humi_sum_ff <= '0;
         count_ff    <= 8'd0;
      end else begin
         window_ff   <= window_in;
         temp_sum_ff <= temp_sum_in;
         humi_sum_ff <= humi_sum_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      divr_ff      <= divr_in;
      t_neg_ff     <= t_neg_in;
      t_rem_ff     <= t_rem_in;
      h_rem_ff     <= h_rem_in;
      t_quo_ff     <= t_quo_in;
      h_quo_ff     <= h_quo_in;
      mean_temp_ff <= mean_temp_in;
      mean_humi_ff <= mean_humi_in;
   end

   assign rsp_mean_temp = mean_temp_ff;
   assign rsp_mean_humi = mean_humi_ff;

endmodule

`default_nettype wire

@@ rtl/cba_ctrl.sv @@
`default_nettype none

`include "clamped_block_averager_unit_defines.svh"

module cba_ctrl
   import cba_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type sts,
   output cmd_type         cmd
);

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                div_last;

   assign div_last = (step_ff == STEP_W'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accum = 1'b1;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sts.window_hit) begin
               cmd.div_load = 1'b1;
               step_in      = '0;
               state_in     = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (div_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.out_load;
   end

   assign rsp_valid = rsp_valid_ff;

   `CBA_ASSERT_NEXT(a_div_ends, (state_ff == ST_DIV) && div_last, (state_ff == ST_OUT))
   `CBA_ASSERT_NEXT(a_load_shows, cmd.out_load, rsp_valid_ff)
   `CBA_ASSERT_NEXT(a_accum_evals, cmd.accum, (state_ff == ST_EVAL))
   `CBA_ASSERT_NOW(a_no_overwrite, cmd.out_load, (!rsp_valid_ff || rsp_ready))

endmodule

`default_nettype wire

@@ rtl/clamped_block_averager_unit.sv @@
// Channel   Handshake              Payload
// req       req_valid/req_ready    req_sample_ok, req_temp_sample, req_humi_sample
// rsp       rsp_valid/rsp_ready    rsp_mean_temp, rsp_mean_humi
// csr       csr_wr_en              csr_wr_data (window length)
//
// An item that closes no window passes through accumulate and window check.
// An item that closes a window also has the two restoring dividers run 14 steps
// side by side, one quotient bit per cycle, then loads the output register.
// Reset is synchronous: sums and count clear, window length returns to 10.
// A waiting result does not block accumulation; only a new result waits for rsp_ready.
`default_nettype none

module clamped_block_averager_unit
   import cba_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [7:0]              csr_wr_data,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_sample_ok,
   input  wire logic signed [15:0]      req_temp_sample,
   input  wire logic signed [15:0]      req_humi_sample,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [OUT_W-1:0]      rsp_mean_temp,
   output logic [OUT_W-1:0]             rsp_mean_humi
);

   cmd_type    cmd;
   status_type sts;

   cba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cba_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_sample_ok   (req_sample_ok),
      .req_temp_sample (req_temp_sample),
      .req_humi_sample (req_humi_sample),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_mean_temp   (rsp_mean_temp),
      .rsp_mean_humi   (rsp_mean_humi)
   );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import cba_pkg::*;

   typedef struct {
      logic               ok;
      logic signed [15:0] temp;
      logic signed [15:0] humi;
   } sample_type;

   typedef struct {
      logic signed [OUT_W-1:0] temp;
      logic [OUT_W-1:0]        humi;
   } average_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_wr_en = 1'b0;
   logic [7:0]              csr_wr_data = 8'd0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_sample_ok = 1'b0;
   logic signed [15:0]      req_temp_sample = 16'sd0;
   logic signed [15:0]      req_humi_sample = 16'sd0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_mean_temp;
   logic [OUT_W-1:0]        rsp_mean_humi;

   sample_type  sample_fifo[$];
   average_type average_fifo[$];

   int unsigned window_cfg = WINDOW_RESET;
   int          temp_acc = 0;
   int unsigned humi_acc = 0;
   int unsigned sample_cnt = 0;

   int          fail_count = 0;
   int          send_gap = 0;
   int          recv_gap = 0;
   logic        steady = 1'b0;
   logic        hold_start = 1'b0;
   logic        rsp_hold = 1'b0;

   clamped_block_averager_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_ok   (req_sample_ok),
      .req_temp_sample (req_temp_sample),
      .req_humi_sample (req_humi_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mean_temp   (rsp_mean_temp),
      .rsp_mean_humi   (rsp_mean_humi)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned round_div(input int unsigned mag, input int unsigned n);
      return (2 * mag + n) / (2 * n);
   endfunction

   function automatic void accumulate_sample(input sample_type s);
      int          t;
      int          h;
      int          at;
      int unsigned w;
      average_type r;
      w = (window_cfg < 1) ? 1 : window_cfg;
      if (w > MAX_WINDOW) w = MAX_WINDOW;
      if (s.ok && sample_cnt < MAX_WINDOW) begin
         t = int'(s.temp);
         h = int'(s.humi);
         if (t < int'(TEMP_MIN)) t = int'(TEMP_MIN);
         if (t > int'(TEMP_MAX)) t = int'(TEMP_MAX);
         if (h < int'(HUMI_MIN)) h = int'(HUMI_MIN);
         if (h > int'(HUMI_MAX)) h = int'(HUMI_MAX);
         temp_acc += t;
         humi_acc += h;
         sample_cnt++;
      end
      if (sample_cnt != 0 && sample_cnt >= w) begin
         if (temp_acc < 0)
            at = -int'(round_div(-temp_acc, sample_cnt));
         else
            at = int'(round_div(temp_acc, sample_cnt));
         r.temp = at[OUT_W-1:0];
         r.humi = OUT_W'(round_div(humi_acc, sample_cnt));
         average_fifo.push_back(r);
         temp_acc = 0;
         humi_acc = 0;
         sample_cnt = 0;
      end
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin : driver
      sample_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready)
            accumulate_sample('{req_sample_ok, req_temp_sample, req_humi_sample});
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (sample_fifo.size() != 0) begin
               next_item = sample_fifo.pop_front();
               req_sample_ok <= next_item.ok;
               req_temp_sample <= next_item.temp;
               req_humi_sample <= next_item.humi;
               req_valid <= 1'b1;
               if (!steady && $urandom_range(0, 7) == 0)
                  send_gap <= $urandom_range(1, 5);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      average_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (average_fifo.size() == 0) begin
               $display("%0t: unexpected item mean_temp %0d mean_humi %0d",
                        $time, rsp_mean_temp, rsp_mean_humi);
               fail_count++;
            end else begin
               want = average_fifo.pop_front();
               if (rsp_mean_temp !== want.temp)
                  report_mismatch("mean_temp", want.temp, rsp_mean_temp);
               if (rsp_mean_humi !== want.humi)
                  report_mismatch("mean_humi", want.humi, rsp_mean_humi);
            end
         end
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 7) == 0)
               recv_gap <= $urandom_range(1, 5);
         end
      end
   end

   // hold off the result side long enough for the input to back up
   initial begin
      wait (hold_start);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic push_item(input logic ok, input logic signed [15:0] t,
                            input logic signed [15:0] h);
      sample_type s;
      s.ok = ok;
      s.temp = t;
      s.humi = h;
      sample_fifo.push_back(s);
   endtask

   task automatic drain();
      do
         @(negedge clock);
      while (sample_fifo.size() != 0 || req_valid || average_fifo.size() != 0);
   endtask

   task automatic set_window(input int unsigned w);
      drain();
      repeat (20) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= w[7:0];
      window_cfg = w;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic sample_type random_sample();
      sample_type s;
      int         kind;
      int         v;
      kind = $urandom_range(0, 19);
      s.ok = (kind > 1);
      if (kind < 5) begin
         s.temp = 16'($urandom);
         s.humi = 16'($urandom);
      end else if (kind == 5) begin
         s.temp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         s.humi = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end else begin
         v = int'($urandom_range(0, 12010)) - 4005;
         s.temp = v[15:0];
         v = int'($urandom_range(0, 10010)) - 5;
         s.humi = v[15:0];
      end
      return s;
   endfunction

   initial begin : stimulus
      int          total;
      int          phase;
      int unsigned w;
      int          n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // window left at its reset length
      push_item(1'b1, -16'sd32768, -16'sd32768);
      push_item(1'b1, 16'sd32767, 16'sd32767);
      push_item(1'b0, 16'sh7FFF, 16'sh8000);
      push_item(1'b1, -16'sd4000, 16'sd0);
      push_item(1'b1, 16'sd8000, 16'sd10000);
      push_item(1'b1, -16'sd4001, -16'sd1);
      push_item(1'b1, 16'sd8001, 16'sd10001);
      push_item(1'b1, 16'sd0, 16'sd0);
      push_item(1'b1, -16'sd1, 16'sd1);
      push_item(1'b1, 16'sd1234, 16'sd5678);
      push_item(1'b1, -16'sd5, 16'sd3);

      // halves round away from zero
      set_window(2);
      push_item(1'b1, -16'sd1, 16'sd1);
      push_item(1'b1, 16'sd0, 16'sd0);
      push_item(1'b1, 16'sd1, 16'sd1);
      push_item(1'b1, 16'sd0, 16'sd0);
      push_item(1'b1, -16'sd3, 16'sd2);
      push_item(1'b1, 16'sd0, 16'sd1);

      set_window(0);
      push_item(1'b1, 16'sd100, 16'sd200);
      push_item(1'b0, 16'sd5, 16'sd5);

      // lower the window below the count already held, close on a failed read
      set_window(5);
      push_item(1'b1, 16'sd7000, 16'sd9000);
      push_item(1'b1, -16'sd3000, 16'sd10);
      push_item(1'b1, 16'sd11, 16'sd4);
      set_window(2);
      push_item(1'b0, 16'sd0, 16'sd0);

      set_window(1);
      hold_start = 1'b1;
      repeat (30) sample_fifo.push_back(random_sample());

      total = 0;
      phase = 0;
      while (total < 650) begin
         if (phase == 0)
            w = MAX_WINDOW;
         else if (phase == 1)
            w = 0;
         else if ($urandom_range(0, 9) == 0)
            w = $urandom_range(0, 255);
         else
            w = $urandom_range(1, 8);
         n = (w > 16) ? w + $urandom_range(0, 20) : $urandom_range(20, 60);
         set_window(w);
         repeat (n) sample_fifo.push_back(random_sample());
         total += n;
         phase++;
      end

      set_window(3);
      steady = 1'b1;
      repeat (60) sample_fifo.push_back(random_sample());

      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && average_fifo.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
